// ===== sv/slash_pkg.sv =====
// Package: shared types, constants and S-box function for the six-lane hash unit.
package slash_pkg;

  localparam int LengthBitsDefault = 32;
  localparam int MsgLenW = 32;

  localparam logic [63:0] K_PHI = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] K_M1  = 64'h85EBCA77C2B2AE3D;
  localparam logic [63:0] K_M2  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] K_M3  = 64'h94D049BB133111EB;
  localparam logic [63:0] K_M4  = 64'hA3C8B9D5E1F2A7B4;
  localparam logic [63:0] K_M5  = 64'hC6A4A7935BD1E995;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_DROPPED = 1'b1;

  typedef struct packed {
    logic        command;
    logic [63:0] seed;
    logic [31:0] message_length;
    logic [63:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_value;
    logic        status;
  } out_item_t;

  // Multiplier job handed to the shared multiply unit.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  typedef logic [3:0][63:0] word4_t;

  function automatic word4_t sbox4(input word4_t v);
    logic [63:0] a, b, c, d;
    word4_t r;
    a = v[0]; b = v[1]; c = v[2]; d = v[3];
    a ^= b & c; b ^= a | d; d ^= b | c; c ^= b & d; b ^= a | c; a ^= b | d;
    r[0] = b; r[1] = c; r[2] = d; r[3] = a;
    return r;
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] k);
    return (x << k) | (x >> (7'd64 - {1'b0, k}));
  endfunction

endpackage

// ===== sv/six_lane_arx_sbox_hash_unit.sv =====
// Top level: six-lane seeded ARX/S-box hash with a sequencer around one shared multiplier.
//
//  channel | dir | ports                          | payload
//  in      | in  | in_valid, in_ready, in_data    | command, seed, message_length, data_word
//  out     | out | out_valid, out_ready, out_data | hash_value, status
//
// A start item has the multiply that forms z and then the six lane multiplies,
// plus the finish when the length is zero. Buffered data words go into the group
// buffer on acceptance; the sixth word of a group adds the group mix, one lane step or S-box pass at a time.
// A tail word is mixed in the tail state. The finish takes a fold step, three multiplies
// on the shared 4-step multiplier with an xor-shift after each, and a final load
// of the output register; the multiplies set the rate.
// in_ready is low while busy and while a result waits that the receiver is not
// taking in the same cycle. Reset is synchronous, active low.
module six_lane_arx_sbox_hash_unit #(
  parameter int LENGTH_BITS = slash_pkg::LengthBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  slash_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output slash_pkg::out_item_t out_data
);
  import slash_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_Z, S_LANES, S_ARX, S_SBOX, S_PAIR, S_TAIL,
    S_FOLD, S_FMUL, S_FXOR, S_OUT
  } state_t;

  localparam logic [63:0] LMask = (LENGTH_BITS >= 64) ? '1 :
                                  ((64'd1 << (LENGTH_BITS % 64)) - 64'd1);

  state_t      state_r;
  logic [5:0][63:0] lane_r;
  logic [4:0][63:0] gbuf_r;
  logic [63:0] last_r, z_r, h_r;
  logic [31:0] rem_r;
  logic [2:0]  fill_r, tail_r, idx_r;
  logic        parity_r, open_r;
  logic [1:0]  fstep_r;
  logic        mwait_r;
  logic        out_valid_r;
  out_item_t   out_r;
  mul_req_t    mreq;
  mul_rsp_t    mrsp;

  slash_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  function automatic logic [63:0] lane_mul(input logic [2:0] i);
    case (i)
      3'd0: return K_PHI;
      3'd1: return K_M1;
      3'd2: return K_M2;
      3'd3: return K_M3;
      3'd4: return K_M4;
      default: return K_M5;
    endcase
  endfunction

  function automatic logic [5:0] lane_rot(input logic [2:0] i);
    case (i)
      3'd0: return 6'd11;
      3'd1: return 6'd17;
      3'd2: return 6'd23;
      3'd3: return 6'd29;
      3'd4: return 6'd35;
      default: return 6'd43;
    endcase
  endfunction

  function automatic logic [2:0] plus3(input logic [2:0] i);
    return (i >= 3'd3) ? i - 3'd3 : i + 3'd3;
  endfunction

  // Pair schedule: step k of 6 picks target, source and rotation.
  logic [2:0] pi, pj;
  logic [5:0] pr;
  always_comb begin
    pi = 3'd0; pj = 3'd1; pr = 6'd17;
    case ({parity_r, idx_r})
      4'b1_000: begin pi = 3'd0; pj = 3'd2; pr = 6'd13; end
      4'b1_001: begin pi = 3'd2; pj = 3'd0; pr = 6'd31; end
      4'b1_010: begin pi = 3'd1; pj = 3'd3; pr = 6'd19; end
      4'b1_011: begin pi = 3'd3; pj = 3'd1; pr = 6'd37; end
      4'b1_100: begin pi = 3'd4; pj = 3'd5; pr = 6'd23; end
      4'b1_101: begin pi = 3'd5; pj = 3'd4; pr = 6'd41; end
      4'b0_000: begin pi = 3'd0; pj = 3'd1; pr = 6'd17; end
      4'b0_001: begin pi = 3'd1; pj = 3'd0; pr = 6'd29; end
      4'b0_010: begin pi = 3'd2; pj = 3'd3; pr = 6'd23; end
      4'b0_011: begin pi = 3'd3; pj = 3'd2; pr = 6'd37; end
      4'b0_100: begin pi = 3'd4; pj = 3'd5; pr = 6'd31; end
      4'b0_101: begin pi = 3'd5; pj = 3'd4; pr = 6'd43; end
      default: ;
    endcase
  end

  // Fold: both S-box steps of the finish on the three XOR pairs.
  logic [63:0] fold_h;
  always_comb begin
    word4_t s1, s2;
    logic [63:0] h1, h3, h5;
    h1 = lane_r[0] ^ lane_r[1];
    h3 = lane_r[2] ^ lane_r[3];
    h5 = lane_r[4] ^ lane_r[5];
    s1 = sbox4({h1, h5, h3, h1});
    h1 = s1[3] ^ s1[1] ^ s1[2];
    s2 = sbox4({h1, h1, h1, h1});
    fold_h = s2[3];
  end

  logic [63:0] fmul_k;
  logic [5:0]  fsh;
  always_comb begin
    case (fstep_r)
      2'd0:    begin fmul_k = K_PHI; fsh = 6'd29; end
      2'd1:    begin fmul_k = K_M1;  fsh = 6'd31; end
      2'd2:    begin fmul_k = K_M2;  fsh = 6'd37; end
      default: begin fmul_k = K_M2;  fsh = 6'd41; end
    endcase
  end

  logic [63:0] tail_mask;
  assign tail_mask = (rem_r >= 32'd8) ? '1 : ((64'd1 << {rem_r[2:0], 3'b000}) - 64'd1);

  logic [63:0] arx_sum;
  assign arx_sum = lane_r[idx_r] + lane_r[plus3(idx_r)];

  logic fire_in, fire_out;
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign fire_in   = in_valid && in_ready;
  assign fire_out  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    mreq = '0;
    if (state_r == S_IDLE && fire_in && in_data.command == CMD_START) begin
      mreq.start = 1'b1;
      mreq.a = {{(64 - MsgLenW){1'b0}}, in_data.message_length} & LMask;
      mreq.b = K_PHI;
    end else if (state_r == S_LANES && !mwait_r) begin
      mreq.start = 1'b1; mreq.a = z_r; mreq.b = lane_mul(idx_r);
    end else if (state_r == S_FMUL && !mwait_r) begin
      mreq.start = 1'b1; mreq.a = h_r; mreq.b = fmul_k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      open_r <= 1'b0;
      rem_r <= '0;
      fill_r <= '0;
      tail_r <= '0;
      parity_r <= 1'b0;
      idx_r <= '0;
      fstep_r <= '0;
      mwait_r <= 1'b0;
      lane_r <= '0;
    end else begin
      if (fire_out) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (fire_in) begin
            if (in_data.command == CMD_START) begin
              z_r <= in_data.seed;
              rem_r <= in_data.message_length & LMask[31:0];
              fill_r <= '0; tail_r <= '0; parity_r <= 1'b0;
              state_r <= S_Z;
            end else if (!open_r) begin
              out_r.hash_value <= '0;
              out_r.status <= ST_DROPPED;
              out_valid_r <= 1'b1;
            end else if (fill_r != 3'd0 || rem_r >= 32'd48) begin
              rem_r <= rem_r - 32'd8;
              if (fill_r < 3'd5) begin
                gbuf_r[fill_r] <= in_data.data_word;
                fill_r <= fill_r + 3'd1;
                if (rem_r == 32'd8) state_r <= S_FOLD;
              end else begin
                fill_r <= '0;
                for (int k = 0; k < 5; k++) lane_r[k] <= lane_r[k] ^ gbuf_r[k];
                lane_r[5] <= lane_r[5] ^ in_data.data_word;
                idx_r <= '0;
                state_r <= S_ARX;
              end
            end else begin
              last_r <= in_data.data_word;
              idx_r <= tail_r;
              state_r <= S_TAIL;
            end
          end
        end
        S_Z: begin
          if (mrsp.done) begin
            z_r <= z_r ^ mrsp.p;
            idx_r <= '0; mwait_r <= 1'b0;
            state_r <= S_LANES;
          end
        end
        S_LANES: begin
          mwait_r <= 1'b1;
          if (mrsp.done) begin
            lane_r[idx_r] <= mrsp.p;
            mwait_r <= 1'b0;
            if (idx_r == 3'd5) begin
              if (rem_r == '0) begin open_r <= 1'b0; state_r <= S_FOLD; end
              else begin open_r <= 1'b1; state_r <= S_IDLE; end
            end
            idx_r <= idx_r + 3'd1;
          end
        end
        S_ARX: begin
          lane_r[idx_r] <= rotl64(arx_sum, lane_rot(idx_r));
          idx_r <= (idx_r == 3'd5) ? 3'd0 : idx_r + 3'd1;
          if (idx_r == 3'd5) state_r <= S_SBOX;
        end
        S_SBOX: begin
          word4_t s;
          // Hold the two passes on separate cycles.
          if (idx_r == 3'd0) begin
            s = sbox4({lane_r[3], lane_r[2], lane_r[1], lane_r[0]});
            {lane_r[3], lane_r[2], lane_r[1], lane_r[0]} <= s;
            idx_r <= 3'd1;
          end else begin
            s = sbox4({lane_r[5], lane_r[4], lane_r[3], lane_r[2]});
            {lane_r[5], lane_r[4], lane_r[3], lane_r[2]} <= s;
            idx_r <= 3'd0;
            state_r <= S_PAIR;
          end
        end
        S_PAIR: begin
          lane_r[pi] <= rotl64(lane_r[pi] + lane_r[pj], pr);
          idx_r <= idx_r + 3'd1;
          if (idx_r == 3'd5) begin
            parity_r <= ~parity_r;
            state_r <= (rem_r == '0) ? S_FOLD : S_IDLE;
          end
        end
        S_TAIL: begin
          if (rem_r >= 32'd8) rem_r <= rem_r - 32'd8;
          else rem_r <= '0;
          lane_r[idx_r] <= rotl64((lane_r[idx_r] ^ (last_r & tail_mask)) +
                                  lane_r[plus3(idx_r)], lane_rot(idx_r));
          tail_r <= (idx_r == 3'd5) ? 3'd0 : idx_r + 3'd1;
          state_r <= (rem_r <= 32'd8) ? S_FOLD : S_IDLE;
        end
        S_FOLD: begin
          open_r <= 1'b0;
          h_r <= fold_h ^ (fold_h >> 29);
          fstep_r <= '0; mwait_r <= 1'b0;
          state_r <= S_FMUL;
        end
        S_FMUL: begin
          mwait_r <= 1'b1;
          if (mrsp.done) begin
            h_r <= mrsp.p;
            mwait_r <= 1'b0;
            fstep_r <= fstep_r + 2'd1;
            state_r <= S_FXOR;
          end
        end
        S_FXOR: begin
          h_r <= h_r ^ (h_r >> fsh);
          state_r <= (fstep_r == 2'd3) ? S_OUT : S_FMUL;
        end
        S_OUT: begin
          // Advance once the earlier result is gone.
          if (!out_valid_r || fire_out) begin
            out_r.hash_value <= h_r;
            out_r.status <= ST_DONE;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_drop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_DROPPED) |-> (out_data.hash_value == '0))
    else $error("dropped item with nonzero hash");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 3'd5) else $error("group fill overflow");
`endif
endmodule

// ===== sv/slash_mul.sv =====
// Shared 64x64 low-half multiplier built from 32x32 partial products.
module slash_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  slash_pkg::mul_req_t req,
  output slash_pkg::mul_rsp_t rsp
);
  import slash_pkg::*;

  logic [63:0] a_r, b_r, acc_r;
  logic [63:0] pp_r;
  logic [2:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] opa, opb;

  always_comb begin
    case (step_r)
      3'd0:    begin opa = a_r[31:0];  opb = b_r[31:0];  end
      3'd1:    begin opa = a_r[31:0];  opb = b_r[63:32]; end
      default: begin opa = a_r[63:32]; opb = b_r[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // Register each partial product and accumulate it in the following cycle.
        pp_r <= opa * opb;
        if (step_r != 3'd0) begin
          if (step_r == 3'd1) acc_r <= acc_r + pp_r;
          else                acc_r <= acc_r + {pp_r[31:0], 32'd0};
        end
        step_r <= step_r + 3'd1;
        if (step_r == 3'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;
endmodule
